// ===== design/sts_pkg.sv =====
// shared token codes, pending operator codes and keyword lookup for the script token scanner
package sts_pkg;

    // token kinds
    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACKET = 6'd2;
    localparam logic [5:0] K_RBRACKET = 6'd3;
    localparam logic [5:0] K_LBRACE   = 6'd4;
    localparam logic [5:0] K_RBRACE   = 6'd5;
    localparam logic [5:0] K_COMMA    = 6'd6;
    localparam logic [5:0] K_DOT      = 6'd7;
    localparam logic [5:0] K_MINUS    = 6'd8;
    localparam logic [5:0] K_PLUS     = 6'd9;
    localparam logic [5:0] K_SEMI     = 6'd10;
    localparam logic [5:0] K_SLASH    = 6'd11;
    localparam logic [5:0] K_STAR     = 6'd12;
    localparam logic [5:0] K_BANG     = 6'd13;
    localparam logic [5:0] K_EQUAL    = 6'd15;
    localparam logic [5:0] K_GREATER  = 6'd17;
    localparam logic [5:0] K_LESS     = 6'd19;
    localparam logic [5:0] K_IDENT    = 6'd21;
    localparam logic [5:0] K_STR      = 6'd22;
    localparam logic [5:0] K_NUM      = 6'd23;
    localparam logic [5:0] K_KW0      = 6'd24;
    localparam logic [5:0] K_EOF      = 6'd40;
    localparam logic [5:0] K_ERR_STR  = 6'd41;
    localparam logic [5:0] K_ERR_CHAR = 6'd42;

    // pending operator codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_BANG  = 3'd1;
    localparam logic [2:0] OP_EQUAL = 3'd2;
    localparam logic [2:0] OP_LESS  = 3'd3;
    localparam logic [2:0] OP_GREAT = 3'd4;

    localparam int KW_COUNT = 16;
    localparam int PREFIX_DEPTH = 7;

    // keyword text, right aligned, first character in the highest used byte
    localparam logic [KW_COUNT-1:0][55:0] KW_TEXT = '{
        56'("while"), 56'("var"), 56'("true"), 56'("this"),
        56'("super"), 56'("return"), 56'("print"), 56'("or"),
        56'("nil"), 56'("if"), 56'("fun"), 56'("for"),
        56'("false"), 56'("else"), 56'("class"), 56'("and")
    };
    localparam logic [KW_COUNT-1:0][2:0] KW_LEN = '{
        3'd5, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd2,
        3'd3, 3'd2, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3
    };

    // kind of a closed word of at most six bytes
    function automatic logic [5:0] word_kind(input logic [PREFIX_DEPTH-1:0][7:0] pre,
                                             input logic [2:0] len);
        logic [5:0] kind;
        logic       match;
        int         k;
        int         i;
        kind = K_IDENT;
        for (k = KW_COUNT - 1; k >= 0; k--)
        begin
            match = (KW_LEN[k] == len);
            for (i = 0; i < 6; i++)
            begin
                if (i < int'(KW_LEN[k]))
                begin
                    if (pre[i] != KW_TEXT[k][8*(int'(KW_LEN[k])-1-i) +: 8])
                    begin
                        match = 1'b0;
                    end
                end
            end
            if (match)
            begin
                kind = K_KW0 + 6'(k);
            end
        end
        return kind;
    endfunction

endpackage

// ===== design/sts_scan_core.sv =====
// scanner state and per-byte token logic, up to three tokens per byte
module sts_scan_core #(
    parameter int OFFSET_WIDTH = 24,
    parameter int COUNT_WIDTH  = 16,
    localparam int RES_W = 6 + OFFSET_WIDTH + 3 * COUNT_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            char_code,
    input  logic                  is_end,
    output logic [1:0]            nres,
    output logic [2:0][RES_W-1:0] results
);

    localparam int OW = OFFSET_WIDTH;
    localparam int CW = COUNT_WIDTH;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_OP, M_WORD, M_INT, M_DOT, M_FRAC, M_QUOTED, M_DONE
    } mode_t;

    mode_t                                 mode_reg, mode_next;
    logic                                  quote_reg, quote_next;
    logic [sts_pkg::PREFIX_DEPTH-1:0][7:0] prefix_reg, prefix_next;
    logic [OW-1:0]                         start_reg, start_next;
    logic [CW-1:0]                         len_reg, len_next;
    logic [OW-1:0]                         off_reg, off_next;
    logic [CW-1:0]                         line_reg, line_next;
    logic [CW-1:0]                         col_reg, col_next;
    logic [2:0]                            pend_reg, pend_next;

    function automatic logic [CW-1:0] inc_cnt(input logic [CW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [CW-1:0] sub_floor(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [RES_W-1:0] pack(input logic [5:0] kind, input logic [OW-1:0] st,
                                              input logic [CW-1:0] ln, input logic [CW-1:0] ln_no,
                                              input logic [CW-1:0] col);
        return {col, ln_no, ln, st, kind};
    endfunction

    function automatic logic [5:0] op_kind(input logic [2:0] op);
        logic [5:0] kind;
        unique case (op)
            sts_pkg::OP_BANG:  kind = sts_pkg::K_BANG;
            sts_pkg::OP_LESS:  kind = sts_pkg::K_LESS;
            sts_pkg::OP_GREAT: kind = sts_pkg::K_GREATER;
            default:           kind = sts_pkg::K_EQUAL;
        endcase
        return kind;
    endfunction

    logic          end_b;
    logic          is_letter;
    logic          is_dig;
    logic          take;
    logic          fall;
    logic [1:0]    cnt;
    logic [CW-1:0] col_inc;
    logic [OW-1:0] off_inc;
    logic [OW-1:0] off_dec;
    logic [5:0]    single;
    logic          has_single;
    logic [5:0]    kw;

    assign end_b     = is_end || (char_code == 8'd0);
    assign is_letter = (char_code >= "a" && char_code <= "z") ||
                       (char_code >= "A" && char_code <= "Z") ||
                       char_code == "_" || char_code == "$";
    assign is_dig    = char_code >= "0" && char_code <= "9";
    assign col_inc   = inc_cnt(col_reg);
    assign off_inc   = (&off_reg) ? off_reg : off_reg + 1'b1;
    assign off_dec   = (off_reg != '0) ? off_reg - 1'b1 : '0;
    assign kw        = (len_reg > CW'(6)) ? sts_pkg::K_IDENT
                                          : sts_pkg::word_kind(prefix_reg, len_reg[2:0]);

    // one-byte punctuators
    always_comb
    begin
        has_single = 1'b1;
        single     = sts_pkg::K_LPAREN;
        unique case (char_code)
            "(":     single = sts_pkg::K_LPAREN;
            ")":     single = sts_pkg::K_RPAREN;
            "[":     single = sts_pkg::K_LBRACKET;
            "]":     single = sts_pkg::K_RBRACKET;
            "{":     single = sts_pkg::K_LBRACE;
            "}":     single = sts_pkg::K_RBRACE;
            ",":     single = sts_pkg::K_COMMA;
            ".":     single = sts_pkg::K_DOT;
            "-":     single = sts_pkg::K_MINUS;
            "+":     single = sts_pkg::K_PLUS;
            ";":     single = sts_pkg::K_SEMI;
            "*":     single = sts_pkg::K_STAR;
            default: has_single = 1'b0;
        endcase
    end

    // next state and tokens for the current byte
    always_comb
    begin
        mode_next   = mode_reg;
        quote_next  = quote_reg;
        prefix_next = prefix_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        pend_next   = pend_reg;
        take        = 1'b0;
        fall        = 1'b0;
        cnt         = 2'd0;
        results     = '0;

        unique case (mode_reg)
            M_DONE:
            begin
                results[cnt] = pack(sts_pkg::K_EOF, off_reg, '0, line_reg, col_reg);
                cnt = cnt + 1'b1;
            end
            M_SLASH:
            begin
                if (!end_b && char_code == "/")
                begin
                    take      = 1'b1;
                    mode_next = M_COMMENT;
                end
                else
                begin
                    results[cnt] = pack(sts_pkg::K_SLASH, start_reg, len_reg, line_reg,
                                        sub_floor(col_reg, len_reg));
                    cnt  = cnt + 1'b1;
                    fall = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (!end_b && char_code != 8'h0a)
                begin
                    take = 1'b1;
                end
                else
                begin
                    fall = 1'b1;
                end
            end
            M_OP:
            begin
                pend_next = sts_pkg::OP_NONE;
                if (!end_b && char_code == "=")
                begin
                    take         = 1'b1;
                    len_next     = CW'(2);
                    results[cnt] = pack(op_kind(pend_reg) + 6'd1, start_reg, CW'(2), line_reg,
                                        sub_floor(col_inc, CW'(2)));
                    cnt       = cnt + 1'b1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    results[cnt] = pack(op_kind(pend_reg), start_reg, len_reg, line_reg,
                                        sub_floor(col_reg, len_reg));
                    cnt  = cnt + 1'b1;
                    fall = 1'b1;
                end
            end
            M_WORD:
            begin
                if (!end_b && (is_letter || is_dig))
                begin
                    if (len_reg < CW'(7))
                    begin
                        prefix_next[len_reg[2:0]] = char_code;
                    end
                    len_next = inc_cnt(len_reg);
                    take     = 1'b1;
                end
                else
                begin
                    results[cnt] = pack(kw, start_reg, len_reg, line_reg,
                                        sub_floor(col_reg, len_reg));
                    cnt  = cnt + 1'b1;
                    fall = 1'b1;
                end
            end
            M_INT, M_FRAC:
            begin
                if (!end_b && is_dig)
                begin
                    len_next = inc_cnt(len_reg);
                    take     = 1'b1;
                end
                else if (mode_reg == M_INT && !end_b && char_code == ".")
                begin
                    take      = 1'b1;
                    mode_next = M_DOT;
                end
                else
                begin
                    results[cnt] = pack(sts_pkg::K_NUM, start_reg, len_reg, line_reg,
                                        sub_floor(col_reg, len_reg));
                    cnt  = cnt + 1'b1;
                    fall = 1'b1;
                end
            end
            M_DOT:
            begin
                if (!end_b && is_dig)
                begin
                    len_next  = inc_cnt(inc_cnt(len_reg));
                    take      = 1'b1;
                    mode_next = M_FRAC;
                end
                else
                begin
                    results[cnt] = pack(sts_pkg::K_NUM, start_reg, len_reg, line_reg,
                                        sub_floor(sub_floor(col_reg, CW'(1)), len_reg));
                    cnt = cnt + 1'b1;
                    results[cnt] = pack(sts_pkg::K_DOT, off_dec, CW'(1), line_reg,
                                        sub_floor(col_reg, CW'(1)));
                    cnt  = cnt + 1'b1;
                    fall = 1'b1;
                end
            end
            M_QUOTED:
            begin
                if (end_b)
                begin
                    results[cnt] = pack(sts_pkg::K_ERR_STR, start_reg, len_reg, line_reg,
                                        sub_floor(col_reg, CW'(1)));
                    cnt  = cnt + 1'b1;
                    fall = 1'b1;
                end
                else
                begin
                    take     = 1'b1;
                    len_next = inc_cnt(len_reg);
                    if (char_code == (quote_reg ? 8'h27 : 8'h22))
                    begin
                        results[cnt] = pack(sts_pkg::K_STR, start_reg, len_next, line_reg,
                                            sub_floor(col_inc, len_next));
                        cnt       = cnt + 1'b1;
                        mode_next = M_IDLE;
                    end
                end
            end
            default:
            begin
                fall = 1'b1;
            end
        endcase

        // byte seen from idle
        if (fall)
        begin
            mode_next = M_IDLE;
            if (end_b)
            begin
                results[cnt] = pack(sts_pkg::K_EOF, off_reg, '0, line_reg, col_reg);
                cnt       = cnt + 1'b1;
                mode_next = M_DONE;
            end
            else
            begin
                priority if (char_code == " " || char_code == 8'h0d ||
                             char_code == 8'h09 || char_code == 8'h0a)
                begin
                    take = 1'b1;
                end
                else if (char_code == "/" || char_code == "!" || char_code == "=" ||
                         char_code == "<" || char_code == ">" || is_dig ||
                         char_code == 8'h22 || char_code == 8'h27)
                begin
                    start_next = off_reg;
                    len_next   = CW'(1);
                    take       = 1'b1;
                    priority case (char_code)
                        "/":     mode_next = M_SLASH;
                        "!":
                        begin
                            pend_next = sts_pkg::OP_BANG;
                            mode_next = M_OP;
                        end
                        "=":
                        begin
                            pend_next = sts_pkg::OP_EQUAL;
                            mode_next = M_OP;
                        end
                        "<":
                        begin
                            pend_next = sts_pkg::OP_LESS;
                            mode_next = M_OP;
                        end
                        ">":
                        begin
                            pend_next = sts_pkg::OP_GREAT;
                            mode_next = M_OP;
                        end
                        8'h22:
                        begin
                            quote_next = 1'b0;
                            mode_next  = M_QUOTED;
                        end
                        8'h27:
                        begin
                            quote_next = 1'b1;
                            mode_next  = M_QUOTED;
                        end
                        default: mode_next = M_INT;
                    endcase
                end
                else if (is_letter)
                begin
                    start_next     = off_reg;
                    len_next       = CW'(1);
                    prefix_next[0] = char_code;
                    take           = 1'b1;
                    mode_next      = M_WORD;
                end
                else
                begin
                    start_next   = off_reg;
                    take         = 1'b1;
                    results[cnt] = pack(has_single ? single : sts_pkg::K_ERR_CHAR, off_reg,
                                        CW'(1), line_reg, sub_floor(col_inc, CW'(1)));
                    cnt = cnt + 1'b1;
                end
            end
        end

        // position update for a consumed byte
        if (take)
        begin
            off_next = off_inc;
            if (char_code == 8'h0a)
            begin
                line_next = inc_cnt(line_reg);
                col_next  = CW'(1);
            end
            else
            begin
                col_next = col_inc;
            end
        end
        nres = cnt;
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            quote_reg <= 1'b0;
            start_reg <= '0;
            len_reg   <= '0;
            off_reg   <= '0;
            line_reg  <= CW'(1);
            col_reg   <= CW'(1);
            pend_reg  <= sts_pkg::OP_NONE;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            pend_reg  <= pend_next;
        end
    end

    // word prefix bytes
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ===== design/sts_result_queue.sv =====
// four-entry token queue, takes up to three tokens a cycle and hands out one while out_ready is high
module sts_result_queue #(
    parameter int WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [1:0]            nres,
    input  logic [2:0][WIDTH-1:0] din,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WIDTH-1:0]      out_data,
    output logic                  out_last
);

    logic [3:0][WIDTH:0] entry_reg;
    logic [1:0]          head_reg;
    logic [1:0]          tail_reg;
    logic [2:0]          count_reg;
    logic                pop;
    logic [1:0]          nadd;

    assign room      = count_reg <= 3'd1;
    assign out_valid = count_reg != 3'd0;
    assign pop       = out_valid && out_ready;
    assign nadd      = push ? nres : 2'd0;
    assign out_data  = entry_reg[head_reg][WIDTH-1:0];
    assign out_last  = entry_reg[head_reg][WIDTH];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_reg + 2'(pop);
            tail_reg  <= tail_reg + nadd;
            count_reg <= count_reg + 3'(nadd) - 3'(pop);
        end
    end

    // token storage, last flag on the final token of a byte
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < nadd)
            begin
                entry_reg[tail_reg + 2'(i)] <= {2'(i) == nadd - 2'd1, din[i]};
            end
        end
    end

endmodule

// ===== design/script_token_scanner.sv =====
// top level of the script token scanner
//
//  channel | dir | tdata (low bit up)                          | tlast
//  s_      | in  | char_code[7:0]                              | is_end
//  m_      | out | token_kind, start_offset, token_length,     | last_of_run
//          |     | line_number, column_number, zero fill       |
//
// one source byte per cycle while the queue has room: a byte is registered and
// scanned, its zero to three tokens land in a four-entry queue; input pauses while
// the queue holds more than one token, so bytes yielding several tokens cost extra
// cycles at the output. reset clears the scanner to line 1, column 1, offset 0.
// m_tready low stalls the queue; once it fills, the input register holds its beat.
module script_token_scanner #(
    parameter int OFFSET_WIDTH = 24,
    parameter int COUNT_WIDTH  = 16,
    localparam int RES_W  = 6 + OFFSET_WIDTH + 3 * COUNT_WIDTH,
    localparam int DATA_W = ((RES_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // char_code
    input  logic              s_tlast,   // is_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // token_kind, start_offset, token_length, line, column
    output logic              m_tlast    // last_of_run
);

    logic                  in_valid_reg;
    logic [7:0]            char_reg;
    logic                  end_reg;
    logic                  room;
    logic                  step;
    logic [1:0]            nres;
    logic [2:0][RES_W-1:0] results;
    logic [RES_W-1:0]      q_data;

    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;
    assign m_tdata  = DATA_W'(q_data);

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            char_reg <= s_tdata;
            end_reg  <= s_tlast;
        end
    end

    sts_scan_core #(
        .OFFSET_WIDTH(OFFSET_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .char_code(char_reg),
        .is_end   (end_reg),
        .nres     (nres),
        .results  (results)
    );

    sts_result_queue #(
        .WIDTH(RES_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (step),
        .nres     (nres),
        .din      (results),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (q_data),
        .out_last (m_tlast)
    );

endmodule
